### rtl/fkc_pkg.sv
// Shared types, constants and helper functions of the frame key census table.
package fkc_pkg;

  localparam logic [7:0]  COUNT_LIMIT = 8'h32;
  localparam logic [31:0] CNT_MAX     = 32'hFFFF_FFFF;

  localparam logic [1:0] OUTCOME_HEADERLESS = 2'd0;
  localparam logic [1:0] OUTCOME_HIT        = 2'd1;
  localparam logic [1:0] OUTCOME_ADDED      = 2'd2;
  localparam logic [1:0] OUTCOME_DROPPED    = 2'd3;

  typedef struct packed {
    logic [3:0]  channel;
    logic [7:0]  count_byte0;
    logic [7:0]  count_byte1;
    logic [7:0]  count_byte2;
    logic [7:0]  count_byte3;
    logic [15:0] frame_length;
    logic [7:0]  frame_type;
  } fkc_in_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [5:0]  entry_index;
    logic [31:0] entry_count;
    logic [5:0]  distinct_keys;
    logic [31:0] total_frames;
    logic [31:0] headerless_frames;
  } fkc_out_t;

  typedef struct packed {
    logic accept;
    logic search;
    logic commit;
  } fkc_cmd_t;

  typedef struct packed {
    logic counted;
    logic hdr_ok;
    logic search_done;
  } fkc_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } fkc_state_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

### rtl/frame_key_census_table.sv
// Top level of the frame key census table: controller, datapath and checks.
//
// Usage: frame headers arrive on the in_ channel (valid/ready) as one fkc_in_t.
// A header is counted only on channel 0 while count_enable, written through the
// cfg_ channel, is set; other headers are taken and give no result.
// Each counted header gives exactly one fkc_out_t transfer on the out_ channel.
// A header that fails the count-byte test goes from the idle state straight to
// the result state and then to the output register. A valid header searches
// the key table one entry per cycle through the key and count memories until
// it finds a match or passes the last entry in use.
// The output register lets the next header be accepted while a result waits;
// if the receiver still stalls when that header is finished, the block holds
// in its result state and takes no new header until the output register frees.
// Synchronous active-low reset clears count_enable, the number of keys in use
// and both frame counters; table contents need no clearing, as only entries
// below the number in use are ever searched. The cfg_ channel is always ready
// and must be written only while the block is idle.
module frame_key_census_table
  import fkc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 48
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data,
  input  logic     in_valid,
  output logic     in_ready,
  input  fkc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output fkc_out_t out_data
);

  fkc_cmd_t    cmd;
  fkc_status_t status;

  assign cfg_ready = 1'b1;

  fkc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  fkc_dpath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

  a_headerless_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.outcome == OUTCOME_HEADERLESS) |->
      (out_data.entry_index == 6'd0) && (out_data.entry_count == 32'd0))
    else $error("Headerless result carries a table slot.");

  a_added_count_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.outcome == OUTCOME_ADDED) |->
      (out_data.entry_count == 32'd1) && (out_data.distinct_keys != 6'd0))
    else $error("New key result does not start its count at one.");

  a_hit_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.outcome == OUTCOME_HIT) |-> (out_data.entry_count > 32'd1))
    else $error("Matched key has a count below two.");

  a_headerless_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.headerless_frames <= out_data.total_frames))
    else $error("More headerless frames than counted frames.");

endmodule

### rtl/fkc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fkc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 48,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/fkc_ctrl.sv
// Controller state machine that sequences accept, table search and result commit.
module fkc_ctrl
  import fkc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  fkc_status_t status,
  output fkc_cmd_t    cmd
);

  fkc_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.counted) begin
            state_nxt = status.hdr_ok ? ST_SEARCH : ST_RESULT;
          end
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (status.search_done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/fkc_dpath.sv
// Datapath holding the key table, counters, search pointer and output register.
module fkc_dpath
  import fkc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  fkc_in_t     in_data,
  input  fkc_cmd_t    cmd,
  output fkc_status_t status,
  output fkc_out_t    out_data
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int EXT_W = (CNT_W > 6) ? CNT_W : 6;

  logic             enable_r;
  logic [31:0]      key_r, key_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [31:0]      frames_r, frames_nxt;
  logic [31:0]      hdrless_r, hdrless_nxt;
  logic [1:0]       outcome_r, outcome_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [31:0]      cnt_r, cnt_nxt;
  fkc_out_t         out_r, out_nxt;

  logic             rd_en;
  logic [31:0]      key_rdata;
  logic [31:0]      cnt_rdata;
  logic             key_we;
  logic             cnt_we;
  logic             hit;
  logic             scan_more;
  logic             hdr_ok;
  logic [EXT_W-1:0] idx_ext;
  logic [EXT_W-1:0] used_ext;

  fkc_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES), .AW(IDX_W)) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (idx_r),
    .wr_data (key_r),
    .rd_en   (rd_en),
    .rd_addr (scan_r[IDX_W-1:0]),
    .rd_data (key_rdata)
  );

  fkc_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES), .AW(IDX_W)) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_we),
    .wr_addr (idx_r),
    .wr_data (cnt_r),
    .rd_en   (rd_en),
    .rd_addr (scan_r[IDX_W-1:0]),
    .rd_data (cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      used_r    <= '0;
      frames_r  <= '0;
      hdrless_r <= '0;
      cmp_v_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        enable_r <= cfg_data;
      end
      used_r    <= used_nxt;
      frames_r  <= frames_nxt;
      hdrless_r <= hdrless_nxt;
      cmp_v_r   <= cmp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    scan_r    <= scan_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    outcome_r <= outcome_nxt;
    idx_r     <= idx_nxt;
    cnt_r     <= cnt_nxt;
    out_r     <= out_nxt;
  end

  assign hdr_ok = (in_data.count_byte0 != 8'd0) &&
                  (in_data.count_byte0 == in_data.count_byte1) &&
                  (in_data.count_byte0 == in_data.count_byte2) &&
                  (in_data.count_byte0 == in_data.count_byte3) &&
                  (in_data.count_byte0 < COUNT_LIMIT);

  assign scan_more = scan_r < used_r;
  assign hit       = cmp_v_r && (key_rdata == key_r);

  assign status.counted     = enable_r && (in_data.channel == 4'd0);
  assign status.hdr_ok      = hdr_ok;
  assign status.search_done = hit || !scan_more;

  assign key_we = cmd.commit && (outcome_r == OUTCOME_ADDED);
  assign cnt_we = cmd.commit && ((outcome_r == OUTCOME_ADDED) || (outcome_r == OUTCOME_HIT));

  always_comb begin
    key_nxt     = key_r;
    used_nxt    = used_r;
    scan_nxt    = scan_r;
    cmp_v_nxt   = cmp_v_r;
    cmp_idx_nxt = cmp_idx_r;
    frames_nxt  = frames_r;
    hdrless_nxt = hdrless_r;
    outcome_nxt = outcome_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    out_nxt     = out_r;
    rd_en       = 1'b0;
    idx_ext     = EXT_W'(idx_r);
    used_ext    = EXT_W'(used_r);

    if (cmd.accept) begin
      key_nxt     = {in_data.count_byte0, in_data.frame_type, in_data.frame_length};
      scan_nxt    = '0;
      cmp_v_nxt   = 1'b0;
      outcome_nxt = OUTCOME_HEADERLESS;
      idx_nxt     = '0;
      cnt_nxt     = '0;
    end

    if (cmd.search) begin
      if (hit) begin
        outcome_nxt = OUTCOME_HIT;
        idx_nxt     = cmp_idx_r;
        cnt_nxt     = sat_inc(cnt_rdata);
      end else if (!scan_more) begin
        if (used_r < CNT_W'(TABLE_ENTRIES)) begin
          outcome_nxt = OUTCOME_ADDED;
          idx_nxt     = used_r[IDX_W-1:0];
          cnt_nxt     = 32'd1;
        end else begin
          outcome_nxt = OUTCOME_DROPPED;
          idx_nxt     = '0;
          cnt_nxt     = '0;
        end
      end else begin
        rd_en       = 1'b1;
        cmp_v_nxt   = 1'b1;
        cmp_idx_nxt = scan_r[IDX_W-1:0];
        scan_nxt    = scan_r + CNT_W'(1);
      end
    end

    if (cmd.commit) begin
      frames_nxt = sat_inc(frames_r);
      if (outcome_r == OUTCOME_HEADERLESS) begin
        hdrless_nxt = sat_inc(hdrless_r);
      end
      if (outcome_r == OUTCOME_ADDED) begin
        used_nxt = used_r + CNT_W'(1);
      end
      used_ext                  = EXT_W'(used_nxt);
      out_nxt.outcome           = outcome_r;
      out_nxt.entry_index       = idx_ext[5:0];
      out_nxt.entry_count       = cnt_r;
      out_nxt.distinct_keys     = used_ext[5:0];
      out_nxt.total_frames      = frames_nxt;
      out_nxt.headerless_frames = hdrless_nxt;
    end
  end

  assign out_data = out_r;

endmodule
